[rtl/ppp_pkg.sv]
// shared types and constants for the point plane projection block
package ppp_pkg;

	localparam int CFG_IDX_BITS = 2;
	localparam int NUM_AXES = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_NORMAL_X     = 2'd0,
		REG_NORMAL_Y     = 2'd1,
		REG_NORMAL_Z     = 2'd2,
		REG_PLANE_OFFSET = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic degen;
		logic tneg;
		logic ovf;
	} ppp_ctl_t;

endpackage

[rtl/ppp_in_if.sv]
// point channel: valid, ready and one point item
interface ppp_in_if #(
	parameter int COORD_BITS = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] point_z;

	modport source (output valid, output point_x, output point_y, output point_z, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

[rtl/ppp_out_if.sv]
// result channel: valid, ready and one projected point item
interface ppp_out_if #(
	parameter int COORD_BITS = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] proj_x;
	logic signed [COORD_BITS-1:0] proj_y;
	logic signed [COORD_BITS-1:0] proj_z;
	logic                         degenerate;
	logic                         saturated;

	modport source (
		output valid, output proj_x, output proj_y, output proj_z,
		output degenerate, output saturated, input ready
	);
	modport sink (
		input valid, input proj_x, input proj_y, input proj_z,
		input degenerate, input saturated, output ready
	);
endinterface

[rtl/ppp_front.sv]
// front pipeline: dot products, norm, magnitude and divider setup
module ppp_front
	import ppp_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	localparam int CW = COORD_BITS,
	localparam int FW = FRAC_BITS,
	localparam int DW = 2 * CW,
	localparam int QB = CW + FW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [CW-1:0] pnt_i [NUM_AXES],
	input  logic signed [CW-1:0] normal [NUM_AXES],
	input  logic        [CW-1:0] nmag [NUM_AXES],
	input  logic signed [CW-1:0] offset,
	output ppp_ctl_t             ctl_o,
	output logic        [DW-1:0] rem_o,
	output logic        [QB-1:0] lq_o,
	output logic        [DW-1:0] den_o,
	output logic signed [CW-1:0] pnt_o [NUM_AXES]
);

	localparam int PW = 2 * CW;
	localparam int NW = ((2 * CW > CW + FW) ? 2 * CW : CW + FW) + 2;
	localparam int XW = NW + FW;
	localparam int TW = XW - QB;
	localparam int KW = (TW > DW) ? TW : DW;

	ppp_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	logic signed [PW-1:0] prod_s1 [NUM_AXES];
	logic        [DW-1:0] sq_s1 [NUM_AXES];
	logic signed [NW-1:0] num_s2;
	logic        [DW-1:0] den_s2, den_s3, den_s4;
	logic        [NW-1:0] mag_s3;
	logic        [DW-1:0] rem_s4;
	logic        [QB-1:0] lq_s4;
	logic signed [CW-1:0] pnt_s1 [NUM_AXES];
	logic signed [CW-1:0] pnt_s2 [NUM_AXES];
	logic signed [CW-1:0] pnt_s3 [NUM_AXES];
	logic signed [CW-1:0] pnt_s4 [NUM_AXES];

	logic          nzero;
	logic [XW-1:0] dividend;
	logic [TW-1:0] top_part;
	logic          ovf;

	assign nzero = (normal[0] == '0) && (normal[1] == '0) && (normal[2] == '0);

	assign dividend = {mag_s3, {FW{1'b0}}};
	assign top_part = dividend[XW-1:QB];
	assign ovf      = KW'(top_part) >= KW'(den_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: in_valid, degen: nzero, tneg: 1'b0, ovf: 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= '{valid: ctl_s2.valid, degen: ctl_s2.degen, tneg: num_s2[NW-1],
				ovf: 1'b0};
			ctl_s4 <= '{valid: ctl_s3.valid, degen: ctl_s3.degen, tneg: ctl_s3.tneg,
				ovf: ovf};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod_s1[a] <= PW'(normal[a]) * PW'(pnt_i[a]);
				sq_s1[a]   <= DW'(nmag[a]) * DW'(nmag[a]);
				pnt_s1[a]  <= pnt_i[a];
				pnt_s2[a]  <= pnt_s1[a];
				pnt_s3[a]  <= pnt_s2[a];
				pnt_s4[a]  <= pnt_s3[a];
			end
			num_s2 <= NW'(prod_s1[0]) + NW'(prod_s1[1]) + NW'(prod_s1[2])
				+ (NW'(offset) <<< FW);
			den_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			mag_s3 <= num_s2[NW-1] ? -num_s2 : num_s2;
			den_s3 <= den_s2;
			rem_s4 <= DW'(top_part);
			lq_s4  <= dividend[QB-1:0];
			den_s4 <= den_s3;
		end
	end

	assign ctl_o = ctl_s4;
	assign rem_o = rem_s4;
	assign lq_o  = lq_s4;
	assign den_o = den_s4;
	assign pnt_o = pnt_s4;

endmodule

[rtl/ppp_div.sv]
// restoring divider pipeline, one quotient bit per stage
module ppp_div
	import ppp_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	localparam int CW = COORD_BITS,
	localparam int DW = 2 * CW,
	localparam int QB = CW + FRAC_BITS + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ppp_ctl_t             ctl_i,
	input  logic        [DW-1:0] rem_i,
	input  logic        [QB-1:0] lq_i,
	input  logic        [DW-1:0] den_i,
	input  logic signed [CW-1:0] pnt_i [NUM_AXES],
	output ppp_ctl_t             ctl_o,
	output logic        [QB-1:0] lq_o,
	output logic signed [CW-1:0] pnt_o [NUM_AXES]
);

	ppp_ctl_t             ctl_s [QB+1];
	logic        [DW-1:0] rem_s [QB+1];
	logic        [DW-1:0] den_s [QB+1];
	logic        [QB-1:0] lq_s [QB+1];
	logic signed [CW-1:0] pnt_s [QB+1][NUM_AXES];

	assign ctl_s[0] = ctl_i;
	assign rem_s[0] = rem_i;
	assign den_s[0] = den_i;
	assign lq_s[0]  = lq_i;
	assign pnt_s[0] = pnt_i;

	for (genvar k = 1; k <= QB; k++) begin : g_step
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		logic          take;

		assign trial = {rem_s[k-1], lq_s[k-1][QB-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_s[k-1]};
		assign take  = !diff[DW+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
				lq_s[k]  <= {lq_s[k-1][QB-2:0], take};
				den_s[k] <= den_s[k-1];
				pnt_s[k] <= pnt_s[k-1];
			end
		end
	end

	assign ctl_o = ctl_s[QB];
	assign lq_o  = lq_s[QB];
	assign pnt_o = pnt_s[QB];

endmodule

[rtl/ppp_back.sv]
// back pipeline: correction product, clamp, subtract and saturate
module ppp_back
	import ppp_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	localparam int CW = COORD_BITS,
	localparam int FW = FRAC_BITS,
	localparam int QB = CW + FW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ppp_ctl_t             ctl_i,
	input  logic        [QB-1:0] lq_i,
	input  logic signed [CW-1:0] pnt_i [NUM_AXES],
	input  logic        [CW-1:0] nmag [NUM_AXES],
	input  logic                 nneg [NUM_AXES],
	output logic                 res_valid,
	output logic signed [CW-1:0] res_proj [NUM_AXES],
	output logic                 res_degen,
	output logic                 res_sat
);

	localparam int QW = QB + 1;
	localparam int QL = QW / 2;
	localparam int QH = QW - QL;
	localparam int LW = QL + CW;
	localparam int HW = QH + CW;
	localparam int MW = QW + CW;
	localparam int SW = MW - FW;
	localparam int RW = CW + 3;
	localparam logic [QW-1:0] Q_LIM = {1'b1, {QB{1'b0}}};
	localparam logic [CW+1:0] C_LIM = {2'b10, {CW{1'b0}}};
	localparam logic signed [RW-1:0] R_TOP = {{4{1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [RW-1:0] R_BOT = {{4{1'b1}}, {(CW-1){1'b0}}};

	ppp_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	logic        [QW-1:0] qf;
	logic        [LW-1:0] pplo_s1 [NUM_AXES];
	logic        [HW-1:0] pphi_s1 [NUM_AXES];
	logic        [MW-1:0] prod_s2 [NUM_AXES];
	logic        [CW+1:0] cm_s3 [NUM_AXES];
	logic                 neg_s3 [NUM_AXES];
	logic signed [RW-1:0] r_s4 [NUM_AXES];
	logic signed [CW-1:0] pnt_s1 [NUM_AXES];
	logic signed [CW-1:0] pnt_s2 [NUM_AXES];
	logic signed [CW-1:0] pnt_s3 [NUM_AXES];
	logic signed [CW-1:0] pnt_s4 [NUM_AXES];
	logic [NUM_AXES-1:0]  clip;

	assign qf = ctl_i.ovf ? Q_LIM : {1'b0, lq_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				pplo_s1[a] <= LW'(qf[QL-1:0]) * LW'(nmag[a]);
				pphi_s1[a] <= HW'(qf[QW-1:QL]) * HW'(nmag[a]);
				prod_s2[a] <= MW'(pplo_s1[a]) + (MW'(pphi_s1[a]) << QL);
				cm_s3[a]   <= (prod_s2[a][MW-1:FW] > SW'(C_LIM)) ? C_LIM
					: prod_s2[a][FW+CW+1:FW];
				neg_s3[a]  <= ctl_s2.tneg ^ nneg[a];
				r_s4[a]    <= neg_s3[a] ? RW'(pnt_s3[a]) + $signed({1'b0, cm_s3[a]})
					: RW'(pnt_s3[a]) - $signed({1'b0, cm_s3[a]});
				pnt_s1[a]  <= pnt_i[a];
				pnt_s2[a]  <= pnt_s1[a];
				pnt_s3[a]  <= pnt_s2[a];
				pnt_s4[a]  <= pnt_s3[a];
			end
		end
	end

	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			clip[a] = 1'b0;
			if (r_s4[a] > R_TOP) begin
				res_proj[a] = R_TOP[CW-1:0];
				clip[a]     = 1'b1;
			end else if (r_s4[a] < R_BOT) begin
				res_proj[a] = R_BOT[CW-1:0];
				clip[a]     = 1'b1;
			end else begin
				res_proj[a] = r_s4[a][CW-1:0];
			end
			// zero normal passes the point through
			if (ctl_s4.degen) begin
				res_proj[a] = pnt_s4[a];
				clip[a]     = 1'b0;
			end
		end
	end

	assign res_valid = ctl_s4.valid;
	assign res_degen = ctl_s4.degen;
	assign res_sat   = |clip;

endmodule

[rtl/point_plane_projection.sv]
// point plane projection top: config registers, pipeline and output skid stage
// an accepted item passes the front, divider and back stages, then the output register, before result valid
// throughput: one item per cycle while the skid stage is empty; the divider retires one quotient bit per stage
// over COORD_BITS + FRAC_BITS + 1 stages, and an output register plus skid keep ready registered
// reset clears all valids; normal resets to (0, 0, 1.0) and offset to 0
module point_plane_projection
	import ppp_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [COORD_BITS-1:0]   cfg_wdata,
	ppp_in_if.sink                  point,
	ppp_out_if.source               result
);

	localparam int CW = COORD_BITS;
	localparam int FW = FRAC_BITS;
	localparam int DW = 2 * CW;
	localparam int QB = CW + FW + 1;
	localparam logic [CW-1:0] ONE_FX = CW'(1) << FW;

	logic signed [CW-1:0] normal_q [NUM_AXES];
	logic        [CW-1:0] nmag_q [NUM_AXES];
	logic                 nneg_q [NUM_AXES];
	logic signed [CW-1:0] offset_q;
	logic        [CW-1:0] wmag;

	logic                 en;
	logic signed [CW-1:0] pnt_in [NUM_AXES];

	ppp_ctl_t             f_ctl;
	logic        [DW-1:0] f_rem;
	logic        [QB-1:0] f_lq;
	logic        [DW-1:0] f_den;
	logic signed [CW-1:0] f_pnt [NUM_AXES];

	ppp_ctl_t             d_ctl;
	logic        [QB-1:0] d_lq;
	logic signed [CW-1:0] d_pnt [NUM_AXES];

	logic                 res_valid;
	logic signed [CW-1:0] res_proj [NUM_AXES];
	logic                 res_degen;
	logic                 res_sat;
	logic                 arrival;

	logic                 out_v_q;
	logic signed [CW-1:0] out_proj_q [NUM_AXES];
	logic                 out_degen_q;
	logic                 out_sat_q;
	logic                 skid_v_q;
	logic signed [CW-1:0] skid_proj_q [NUM_AXES];
	logic                 skid_degen_q;
	logic                 skid_sat_q;

	assign wmag = cfg_wdata[CW-1] ? -cfg_wdata : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= ONE_FX;
			nmag_q[0]   <= '0;
			nmag_q[1]   <= '0;
			nmag_q[2]   <= ONE_FX;
			for (int a = 0; a < NUM_AXES; a++) begin
				nneg_q[a]   <= 1'b0;
			end
			offset_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_NORMAL_X: begin
					normal_q[0] <= cfg_wdata;
					nmag_q[0]   <= wmag;
					nneg_q[0]   <= cfg_wdata[CW-1];
				end
				REG_NORMAL_Y: begin
					normal_q[1] <= cfg_wdata;
					nmag_q[1]   <= wmag;
					nneg_q[1]   <= cfg_wdata[CW-1];
				end
				REG_NORMAL_Z: begin
					normal_q[2] <= cfg_wdata;
					nmag_q[2]   <= wmag;
					nneg_q[2]   <= cfg_wdata[CW-1];
				end
				REG_PLANE_OFFSET: begin
					offset_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// pipeline moves while the skid stage is empty
	assign en          = !skid_v_q;
	assign point.ready = en;

	assign pnt_in[0] = point.point_x;
	assign pnt_in[1] = point.point_y;
	assign pnt_in[2] = point.point_z;

	ppp_front #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (point.valid),
		.pnt_i    (pnt_in),
		.normal   (normal_q),
		.nmag     (nmag_q),
		.offset   (offset_q),
		.ctl_o    (f_ctl),
		.rem_o    (f_rem),
		.lq_o     (f_lq),
		.den_o    (f_den),
		.pnt_o    (f_pnt)
	);

	ppp_div #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (f_ctl),
		.rem_i  (f_rem),
		.lq_i   (f_lq),
		.den_i  (f_den),
		.pnt_i  (f_pnt),
		.ctl_o  (d_ctl),
		.lq_o   (d_lq),
		.pnt_o  (d_pnt)
	);

	ppp_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_i     (d_ctl),
		.lq_i      (d_lq),
		.pnt_i     (d_pnt),
		.nmag      (nmag_q),
		.nneg      (nneg_q),
		.res_valid (res_valid),
		.res_proj  (res_proj),
		.res_degen (res_degen),
		.res_sat   (res_sat)
	);

	assign arrival = res_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			out_v_q  <= skid_v_q || arrival;
			skid_v_q <= 1'b0;
		end else if (arrival) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			if (skid_v_q) begin
				out_proj_q  <= skid_proj_q;
				out_degen_q <= skid_degen_q;
				out_sat_q   <= skid_sat_q;
			end else if (arrival) begin
				out_proj_q  <= res_proj;
				out_degen_q <= res_degen;
				out_sat_q   <= res_sat;
			end
		end else if (arrival) begin
			skid_proj_q  <= res_proj;
			skid_degen_q <= res_degen;
			skid_sat_q   <= res_sat;
		end
	end

	assign result.valid      = out_v_q;
	assign result.proj_x     = out_proj_q[0];
	assign result.proj_y     = out_proj_q[1];
	assign result.proj_z     = out_proj_q[2];
	assign result.degenerate = out_degen_q;
	assign result.saturated  = out_sat_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds an item while the output register is empty");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.degenerate && result.saturated))
		else $error("degenerate and saturated set on the same item");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !result.ready))
		else $error("skid filled without a stalled output");
`endif

endmodule
